/* rtl/mbet_pkg.sv */
package mbet_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_X_DIV,
    S_X_DONE,
    S_Y_DIV,
    S_Y_DONE,
    S_SQ_X,
    S_SQ_Y,
    S_MUL_XY,
    S_TEST,
    S_UPDATE,
    S_END,
    S_G_DIV,
    S_G_DONE,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    DIV_SEL_X,
    DIV_SEL_Y,
    DIV_SEL_G
  } div_sel_t;

  typedef enum logic [1:0] {
    MUL_SEL_XX,
    MUL_SEL_YY,
    MUL_SEL_XY
  } mul_sel_t;

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_LIMIT  = 2'd2;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int LIMIT_RESET  = 255;

  typedef struct packed {
    logic     capture;
    logic     div_load;
    div_sel_t div_sel;
    logic     div_step;
    logic     store_cr;
    logic     store_ci;
    mul_sel_t mul_sel;
    logic     store_xx;
    logic     store_yy;
    logic     store_xy;
    logic     cnt_inc;
    logic     update_z;
    logic     gray_zero;
    logic     store_gray;
    logic     out_load;
  } ctrl_t;

  typedef struct packed {
    logic div_last;
    logic esc_mag;
    logic esc_sum;
    logic cnt_over;
    logic cnt_below;
    logic out_free;
  } stat_t;

endpackage

/* rtl/mbet_ctrl.sv */
module mbet_ctrl
  import mbet_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output ctrl_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_X_DIV;
      S_X_DIV:  if (stat.div_last) state_nxt = S_X_DONE;
      S_X_DONE: state_nxt = S_Y_DIV;
      S_Y_DIV:  if (stat.div_last) state_nxt = S_Y_DONE;
      S_Y_DONE: state_nxt = S_SQ_X;
      S_SQ_X:   state_nxt = stat.esc_mag ? S_END : S_SQ_Y;
      S_SQ_Y:   state_nxt = S_MUL_XY;
      S_MUL_XY: state_nxt = S_TEST;
      S_TEST: begin
        if (stat.esc_sum || stat.cnt_over) state_nxt = S_END;
        else state_nxt = S_UPDATE;
      end
      S_UPDATE: state_nxt = S_SQ_X;
      S_END:    state_nxt = stat.cnt_below ? S_G_DIV : S_FINISH;
      S_G_DIV:  if (stat.div_last) state_nxt = S_G_DONE;
      S_G_DONE: state_nxt = S_FINISH;
      S_FINISH: if (stat.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture  = 1'b1;
          cmd.div_load = 1'b1;
          cmd.div_sel  = DIV_SEL_X;
        end
      end
      S_X_DIV: cmd.div_step = 1'b1;
      S_X_DONE: begin
        cmd.store_cr = 1'b1;
        cmd.div_load = 1'b1;
        cmd.div_sel  = DIV_SEL_Y;
      end
      S_Y_DIV:  cmd.div_step = 1'b1;
      S_Y_DONE: cmd.store_ci = 1'b1;
      S_SQ_X:   cmd.mul_sel = MUL_SEL_XX;
      S_SQ_Y: begin
        cmd.store_xx = 1'b1;
        cmd.mul_sel  = MUL_SEL_YY;
      end
      S_MUL_XY: begin
        cmd.store_yy = 1'b1;
        cmd.mul_sel  = MUL_SEL_XY;
      end
      S_TEST: begin
        cmd.store_xy = 1'b1;
        cmd.cnt_inc  = !stat.esc_sum;
      end
      S_UPDATE: cmd.update_z = 1'b1;
      S_END: begin
        if (stat.cnt_below) begin
          cmd.div_load = 1'b1;
          cmd.div_sel  = DIV_SEL_G;
        end else begin
          cmd.gray_zero = 1'b1;
        end
      end
      S_G_DIV:  cmd.div_step = 1'b1;
      S_G_DONE: cmd.store_gray = 1'b1;
      S_FINISH: cmd.out_load = stat.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

/* rtl/mbet_datapath.sv */
module mbet_datapath
  import mbet_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int ITER_BITS  = 16,
  parameter int FRAC_BITS  = 28
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_t                 cmd,
  output stat_t                 stat,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic [COORD_BITS:0]   image_width,
  input  logic [COORD_BITS:0]   image_height,
  input  logic [ITER_BITS-1:0]  iteration_limit,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [7:0]            gray_level
);

  localparam int QW  = FRAC_BITS + 4;
  localparam int EW  = FRAC_BITS + 6;
  localparam int RW  = FRAC_BITS + 5;
  localparam int MW  = FRAC_BITS + 1;
  localparam int DVA = COORD_BITS + FRAC_BITS;
  localparam int DVB = ITER_BITS + 8;
  localparam int DVW = (DVA > DVB) ? DVA : DVB;
  localparam int DSA = COORD_BITS + 1;
  localparam int DSW = (DSA > ITER_BITS) ? DSA : ITER_BITS;
  localparam int SCW = $clog2(DVW);

  localparam logic signed [EW-1:0] Q_MAX_E = (EW'(8) << FRAC_BITS) - EW'(1);
  localparam logic signed [EW-1:0] Q_MIN_E = -(EW'(8) << FRAC_BITS);
  localparam logic signed [EW-1:0] OFF_X   = EW'(3) << (FRAC_BITS - 1);
  localparam logic signed [EW-1:0] OFF_Y   = EW'(1) << (FRAC_BITS - 1);
  localparam logic signed [EW-1:0] FOUR_E  = EW'(4) << FRAC_BITS;
  localparam logic [QW-1:0]        TWO_Q   = QW'(2) << FRAC_BITS;
  localparam logic [RW-1:0]        SIXTEEN = RW'(1) << (FRAC_BITS + 4);

  function automatic logic signed [QW-1:0] sat_q(input logic signed [EW-1:0] v);
    logic signed [QW-1:0] r;
    if (v > Q_MAX_E) r = Q_MAX_E[QW-1:0];
    else if (v < Q_MIN_E) r = Q_MIN_E[QW-1:0];
    else r = v[QW-1:0];
    return r;
  endfunction

  function automatic logic [QW-1:0] mag_q(input logic signed [QW-1:0] v);
    return v[QW-1] ? QW'(-v) : QW'(v);
  endfunction

  // shared restoring divider
  logic [COORD_BITS-1:0] py_r;
  logic [DVW-1:0]        dvd_r;
  logic [DSW:0]          rem_r;
  logic [DSW-1:0]        dsr_r;
  logic [SCW-1:0]        step_r;
  logic [DSW:0]          sh;
  logic                  ge;
  logic [DVW-1:0]        dvd_nxt;
  logic [DSW-1:0]        dsr_nxt;

  logic [ITER_BITS:0]    count_r;
  logic [ITER_BITS-1:0]  count_lo;

  assign sh       = {rem_r[DSW-1:0], dvd_r[DVW-1]};
  assign ge       = sh >= {1'b0, dsr_r};
  assign count_lo = count_r[ITER_BITS-1:0];

  always_comb begin
    dvd_nxt = DVW'(pixel_x) << FRAC_BITS;
    dsr_nxt = (image_width == '0) ? DSW'(1) : DSW'(image_width);
    case (cmd.div_sel)
      DIV_SEL_Y: begin
        dvd_nxt = DVW'(py_r) << FRAC_BITS;
        dsr_nxt = (image_height == '0) ? DSW'(1) : DSW'(image_height);
      end
      DIV_SEL_G: begin
        dvd_nxt = (DVW'(count_lo) << 8) - DVW'(count_lo);
        dsr_nxt = DSW'(iteration_limit);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) py_r <= pixel_y;
    if (cmd.div_load) begin
      dvd_r  <= dvd_nxt;
      dsr_r  <= dsr_nxt;
      rem_r  <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r  <= {dvd_r[DVW-2:0], ge};
      rem_r  <= ge ? (sh - {1'b0, dsr_r}) : sh;
      step_r <= step_r + SCW'(1);
    end
  end

  // quotient to clamped ratio, then offset and saturate
  logic                 ratio_over;
  logic [RW-1:0]        ratio;
  logic signed [EW-1:0] ratio_e;
  logic signed [QW-1:0] c_nxt;

  assign ratio_over = (dvd_r >> (FRAC_BITS + 4)) != '0;
  assign ratio      = ratio_over ? SIXTEEN : RW'(dvd_r);
  assign ratio_e    = $signed({1'b0, ratio});
  assign c_nxt      = sat_q(ratio_e - (cmd.store_ci ? OFF_Y : OFF_X));

  // iteration
  logic signed [QW-1:0] cr_r, ci_r, x_r, y_r, xx_r, yy_r, xy_r;
  logic [QW-1:0]        mag_x, mag_y;
  logic [MW-1:0]        mul_a, mul_b;
  logic [2*MW-1:0]      prod_r;
  logic                 neg_r;
  logic [MW:0]          prod_m;
  logic [QW-1:0]        prod_q;
  logic signed [QW-1:0] x_nxt, y_nxt;

  assign mag_x = mag_q(x_r);
  assign mag_y = mag_q(y_r);

  always_comb begin
    mul_a = MW'(mag_x);
    mul_b = MW'(mag_x);
    case (cmd.mul_sel)
      MUL_SEL_YY: begin
        mul_a = MW'(mag_y);
        mul_b = MW'(mag_y);
      end
      MUL_SEL_XY: mul_b = MW'(mag_y);
      default: ;
    endcase
  end

  assign prod_m = (MW + 1)'(prod_r >> FRAC_BITS);
  assign prod_q = neg_r ? -QW'(prod_m) : QW'(prod_m);

  assign x_nxt = sat_q(EW'(xx_r) - EW'(yy_r) + EW'(cr_r));
  assign y_nxt = sat_q((EW'(xy_r) <<< 1) + EW'(ci_r));

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    neg_r  <= (cmd.mul_sel == MUL_SEL_XY) && (x_r[QW-1] ^ y_r[QW-1]);
    if (cmd.store_cr) cr_r <= c_nxt;
    if (cmd.store_ci) begin
      ci_r    <= c_nxt;
      x_r     <= '0;
      y_r     <= '0;
      count_r <= '0;
    end else begin
      if (cmd.update_z) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
      end
      if (cmd.cnt_inc) count_r <= count_r + (ITER_BITS + 1)'(1);
    end
    if (cmd.store_xx) xx_r <= prod_q;
    if (cmd.store_yy) yy_r <= prod_q;
    if (cmd.store_xy) xy_r <= prod_q;
  end

  // result
  logic [7:0] gray_r;
  logic       out_valid_r;
  logic [7:0] out_gray_r;

  always_ff @(posedge clk) begin
    if (cmd.gray_zero) gray_r <= '0;
    else if (cmd.store_gray) gray_r <= dvd_r[7:0];
    if (cmd.out_load) out_gray_r <= gray_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign gray_level = out_gray_r;

  assign stat.div_last  = step_r == SCW'(DVW - 1);
  assign stat.esc_mag   = (mag_x >= TWO_Q) || (mag_y >= TWO_Q);
  assign stat.esc_sum   = (EW'(xx_r) + EW'(yy_r)) >= FOUR_E;
  assign stat.cnt_over  = count_r > (ITER_BITS + 1)'(iteration_limit);
  assign stat.cnt_below = count_r < (ITER_BITS + 1)'(iteration_limit);
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

/* rtl/mandelbrot_escape_time_pixel_core.sv */
// Mandelbrot escape-time pixel core. Each input item is one pixel (x, y); it
// maps to c = (x/width - 1.5, y/height - 0.5) in signed Q4.FRAC_BITS, iterates
// z = z*z + c from zero and returns one item, the gray level
// 255*count/limit (0 when the count reaches the limit). One pixel is in work
// at a time, and at most limit+2 iterations are run. The divider dividend is
// D = max(COORD_BITS+FRAC_BITS, ITER_BITS+8) bits wide, 40 by default: one
// shared restoring divider, one quotient bit per cycle, makes both
// coordinate ratios and the final gray scaling, and a single multiplier
// forms x*x, y*y and x*y in turn. When no division is needed for the
// gray level (count at or above the limit) the last divider pass is skipped.
// A finished result waits in an output register, so the next pixel is
// accepted while it is pending.
module mandelbrot_escape_time_pixel_core
  import mbet_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int ITER_BITS  = 16,
  parameter int FRAC_BITS  = 28,
  localparam int IN_TW     = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int CFG_W     = (COORD_BITS + 1 > ITER_BITS) ? COORD_BITS + 1 : ITER_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_TW-1:0]        in_tdata,   // pixel_x, pixel_y
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [7:0]              out_tdata,  // gray_level
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  logic [COORD_BITS:0]  width_r;
  logic [COORD_BITS:0]  height_r;
  logic [ITER_BITS-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= (COORD_BITS + 1)'(WIDTH_RESET);
      height_r <= (COORD_BITS + 1)'(HEIGHT_RESET);
      limit_r  <= ITER_BITS'(LIMIT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  width_r  <= (COORD_BITS + 1)'(cfg_wdata);
        CFG_IDX_HEIGHT: height_r <= (COORD_BITS + 1)'(cfg_wdata);
        CFG_IDX_LIMIT:  limit_r  <= ITER_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  ctrl_t cmd;
  stat_t stat;

  mbet_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mbet_datapath #(
    .COORD_BITS (COORD_BITS),
    .ITER_BITS  (ITER_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .pixel_x         (in_tdata[COORD_BITS-1:0]),
    .pixel_y         (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .image_width     (width_r),
    .image_height    (height_r),
    .iteration_limit (limit_r),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .gray_level      (out_tdata)
  );

endmodule

/* test/tb_mandelbrot_escape_time_pixel_core.sv */
module tb_mandelbrot_escape_time_pixel_core;
  import mbet_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 28;
  localparam longint Q_ONE = longint'(1) << FRAC;
  localparam longint Q_HI = (longint'(8) << FRAC) - 1;
  localparam longint Q_LO = -(longint'(8) << FRAC);
  localparam longint Q_TWO = longint'(2) << FRAC;
  localparam longint Q_FOUR = longint'(4) << FRAC;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_NONE = 2'd3;
  localparam int HOLD_CYCLES = 2000;
  localparam int RAND_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 72;

  typedef struct packed {
    logic [11:0] y;
    logic [11:0] x;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // pixel_x, pixel_y
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // gray_level
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  // mirror of the block's registers
  logic [12:0] img_width = 13'(WIDTH_RESET);
  logic [12:0] img_height = 13'(HEIGHT_RESET);
  logic [15:0] iter_limit = 16'(LIMIT_RESET);

  pixel_t     pending_pixels[$];
  logic [7:0] expected_gray[$];
  int         queued_count = 0;
  int         accepted_count = 0;
  int         error_count = 0;
  bit         in_took = 1'b0;
  bit         out_took = 1'b0;
  int         in_gap = 0;
  int         out_stall = 0;
  bit         idle_en = 1'b1;
  bit         hold_req = 1'b0;
  int         hold_left = 0;
  logic [7:0] want_gray;
  pixel_t     taken_pixel;

  mandelbrot_escape_time_pixel_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint clamp_q(longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  function automatic longint abs_q(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // truncated product, sign applied after the shift
  function automatic longint q_mul(longint a, longint b);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned p;
    ma = longint'(abs_q(a));
    mb = longint'(abs_q(b));
    p = (ma * mb) >> FRAC;
    p &= (longint'(1) << 62) - 1;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  // floor(n/d) in fixed point, clamped to 16
  function automatic longint coord_ratio(logic [11:0] n, logic [12:0] d);
    longint unsigned nn;
    longint unsigned dd;
    nn = 64'(n);
    dd = (d == 0) ? 64'd1 : 64'(d);
    if (nn / dd >= 16) return longint'(16) << FRAC;
    return longint'((nn << FRAC) / dd);
  endfunction

  function automatic logic [7:0] escape_gray(logic [11:0] px, logic [11:0] py);
    longint      cr;
    longint      ci;
    longint      zr;
    longint      zi;
    longint      sq_r;
    longint      sq_i;
    longint      prod_ri;
    int unsigned count;
    int unsigned prev;
    cr = clamp_q(coord_ratio(px, img_width) - 3 * (Q_ONE >> 1));
    ci = clamp_q(coord_ratio(py, img_height) - (Q_ONE >> 1));
    zr = 0;
    zi = 0;
    count = 0;
    while (1'b1) begin
      if (abs_q(zr) >= Q_TWO || abs_q(zi) >= Q_TWO) break;
      sq_r = q_mul(zr, zr);
      sq_i = q_mul(zi, zi);
      if (sq_r + sq_i >= Q_FOUR) break;
      prev = count;
      count++;
      if (prev > 32'(iter_limit)) break;
      prod_ri = q_mul(zr, zi);
      zr = clamp_q(sq_r - sq_i + cr);
      zi = clamp_q(2 * prod_ri + ci);
    end
    if (count < 32'(iter_limit))
      return 8'((longint'(255) * count) / longint'(iter_limit));
    return 8'd0;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IDX_WIDTH:  img_width = value[12:0];
      CFG_IDX_HEIGHT: img_height = value[12:0];
      CFG_IDX_LIMIT:  iter_limit = value;
      default: ;
    endcase
  endtask

  task automatic push_pixel(int x, int y);
    pixel_t p;
    p.x = 12'(x);
    p.y = 12'(y);
    pending_pixels.push_back(p);
    queued_count++;
  endtask

  task automatic wait_idle();
    while (accepted_count != queued_count || expected_gray.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_took)) begin
      if (in_took) in_gap = idle_en ? $urandom_range(0, 5) : 0;
      if (in_gap == 0 && pending_pixels.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_pixels.pop_front();
      end else begin
        in_tvalid <= 1'b0;
        if (in_gap != 0) in_gap--;
      end
    end
  end

  // long receiver hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) out_stall = idle_en ? $urandom_range(0, 5) : 0;
      if (hold_left != 0 || out_stall != 0) begin
        out_tready <= 1'b0;
        if (hold_left == 0) out_stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    in_took <= rst_n && in_tvalid && in_tready;
    out_took <= rst_n && out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_gray.size() == 0) begin
        report_mismatch($sformatf("gray level %0d with no item pending", out_tdata));
      end else begin
        want_gray = expected_gray.pop_front();
        if (out_tdata !== want_gray)
          report_mismatch($sformatf("gray level %0d, expected %0d", out_tdata, want_gray));
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      taken_pixel = pixel_t'(in_tdata);
      expected_gray.push_back(escape_gray(taken_pixel.x, taken_pixel.y));
      accepted_count++;
    end
  end

  initial begin
    #100_000_000;
    $display("tb_mandelbrot_escape_time_pixel_core: FAIL");
    $finish;
  end

  initial begin
    int w;
    int h;
    int lim;
    int xr;
    int yr;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: corners, c = 0 and c = -1 stay inside
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    push_pixel(0, 4095);
    push_pixel(4095, 0);
    push_pixel(960, 240);
    push_pixel(320, 240);
    push_pixel(1280, 0);
    push_pixel(480, 480);
    wait_idle();

    // zero divisors and zero limit; unused register index is ignored
    write_reg(CFG_IDX_WIDTH, 16'd0);
    write_reg(CFG_IDX_HEIGHT, 16'd0);
    write_reg(CFG_IDX_LIMIT, 16'd0);
    write_reg(CFG_IDX_NONE, 16'hFFFF);
    push_pixel(0, 0);
    push_pixel(1, 0);
    push_pixel(0, 1);
    push_pixel(3, 1);
    push_pixel(4095, 4095);
    wait_idle();

    // widest divisors, limit of one
    write_reg(CFG_IDX_WIDTH, 16'hFFFF);
    write_reg(CFG_IDX_HEIGHT, 16'hFFFF);
    write_reg(CFG_IDX_LIMIT, 16'd1);
    push_pixel(4095, 4095);
    push_pixel(0, 0);
    push_pixel(4095, 2048);
    push_pixel(2000, 4000);
    wait_idle();

    // largest limit: one point that never escapes, the rest leave fast
    write_reg(CFG_IDX_WIDTH, 16'd2);
    write_reg(CFG_IDX_HEIGHT, 16'd2);
    write_reg(CFG_IDX_LIMIT, 16'hFFFF);
    push_pixel(3, 1);
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_en = (ph != 1);
      case (ph)
        0: begin w = 1; h = 1; end
        1: begin w = 4096; h = 4096; end
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            w = $urandom_range(2, 64);
            h = $urandom_range(2, 64);
          end else begin
            w = $urandom_range(1, 4096);
            h = $urandom_range(1, 4096);
          end
        end
      endcase
      lim = (ph == 5) ? LIMIT_RESET : $urandom_range(1, 64);
      write_reg(CFG_IDX_WIDTH, 16'(w));
      write_reg(CFG_IDX_HEIGHT, 16'(h));
      write_reg(CFG_IDX_LIMIT, 16'(lim));
      if (ph == 3) hold_req = 1'b1;
      xr = (2 * w > 4095) ? 4095 : 2 * w;
      yr = (h > 4095) ? 4095 : h;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 3) == 0)
          push_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
        else
          push_pixel($urandom_range(0, xr), $urandom_range(0, yr));
      end
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (expected_gray.size() != 0)
      report_mismatch($sformatf("%0d gray levels never arrived", expected_gray.size()));
    if (error_count == 0)
      $display("tb_mandelbrot_escape_time_pixel_core: PASS");
    else
      $display("tb_mandelbrot_escape_time_pixel_core: FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/mbet_pkg.sv
rtl/mbet_ctrl.sv
rtl/mbet_datapath.sv
rtl/mandelbrot_escape_time_pixel_core.sv
test/tb_mandelbrot_escape_time_pixel_core.sv
